// ===== rtl/bba_pkg.sv =====
// Shared types, constants and codes of the bitmap best-fit allocator.
package bba_pkg;

  localparam int MAP_BITS    = 1024;
  localparam int WORD_BITS   = 8;
  localparam int MAP_WORDS   = MAP_BITS / WORD_BITS;
  localparam int WORD_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int POS_W       = $clog2(MAP_BITS);
  localparam int ADDR_W      = 10;
  localparam int LEN_W       = 11;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   waddr_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [LEN_W-1:0]     len_t;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_QUERY  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init;
    logic step;
    logic alloc;
  } scan_ctl_t;

endpackage

// ===== rtl/bba_map_ram.sv =====
// Allocation bitmap memory with per-word valid bits for instant clearing.
module bba_map_ram (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear_all,
  input  logic           we,
  input  bba_pkg::waddr_t waddr,
  input  bba_pkg::word_t  wdata,
  input  logic           re,
  input  bba_pkg::waddr_t raddr,
  output bba_pkg::word_t  rdata
);
  import bba_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid;
  word_t                rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q     <= mem[raddr];
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/bba_scan.sv =====
// Free-run tracker that applies the best-fit rule one position per step.
module bba_scan (
  input  logic               clk,
  input  bba_pkg::scan_ctl_t ctl,
  input  bba_pkg::pos_t      pos,
  input  bba_pkg::len_t      need,
  output bba_pkg::pos_t      seg_start,
  output bba_pkg::len_t      seg_length,
  output logic               fit_found
);
  import bba_pkg::*;

  len_t cur_len;
  pos_t cur_start;
  len_t best_len;
  pos_t best_start;
  logic take;

  assign take = (cur_len >= need) && ((cur_len <= best_len) || (best_len == '0));

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      cur_len    <= '0;
      cur_start  <= '0;
      best_len   <= '0;
      best_start <= '0;
    end else if (ctl.step) begin
      if (!ctl.alloc) begin
        cur_len <= cur_len + 1'b1;
      end else begin
        if (take) begin
          best_len   <= cur_len;
          best_start <= cur_start;
        end
        cur_len   <= '0;
        cur_start <= pos + 1'b1;
      end
    end
  end

  assign seg_start  = best_start;
  assign seg_length = best_len;
  assign fit_found  = (best_len != '0) && (best_len >= need);

endmodule

// ===== rtl/bitmap_best_fit_allocator.sv =====
// Top level of the bitmap best-fit allocator: request sequencer and result register.
// One request is handled at a time and each gives exactly one result. Set and query
// read the addressed word, and set then writes it back modified (a read-modify-write);
// clear map goes straight to the result register, and a best-fit search has the scan
// unit walk the bitmap one position per cycle while the next 8-bit word is fetched
// from the map memory in the background. After reset the map reads as all free at
// once. A new request is taken as soon as the previous result is in the output
// register, even if it has not been taken yet.
module bitmap_best_fit_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // address[9:0], bit_value[10], wipe_on_free[11], min_length[22:12], zero[23]
  input  logic [bba_pkg::IN_TDATA_W-1:0]    s_tdata,
  // op[1:0]
  input  logic [bba_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bit_read[0], seg_start[10:1], seg_length[21:11], fit_found[22],
  // erase_request[23], erase_address[33:24], zero[39:34]
  output logic [bba_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import bba_pkg::*;

  state_t    state;
  state_t    state_next;
  op_t       op_q;
  addr_t     addr_q;
  logic      bit_q;
  logic      wipe_q;
  len_t      need_q;
  pos_t      pos;
  pos_t      pos_next;
  logic      res_bit_read;
  logic      res_erase;
  logic      accept;
  logic      out_load;
  logic      mem_we;
  word_t     mem_wdata;
  logic      mem_re;
  waddr_t    mem_raddr;
  word_t     mem_rdata;
  logic      clear_all;
  scan_ctl_t scan_ctl;
  pos_t      seg_start;
  len_t      seg_length;
  logic      fit_found;
  addr_t     out_start;
  len_t      out_length;
  logic      out_fit;
  addr_t     out_erase_addr;
  addr_t     in_address;

  assign in_address = s_tdata[ADDR_W-1:0];
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;

  bba_map_ram u_ram (
    .clk       (clk),
    .rst       (rst),
    .clear_all (clear_all),
    .we        (mem_we),
    .waddr     (addr_q[BIT_AW +: WORD_AW]),
    .wdata     (mem_wdata),
    .re        (mem_re),
    .raddr     (mem_raddr),
    .rdata     (mem_rdata)
  );

  bba_scan u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .pos        (pos),
    .need       (need_q),
    .seg_start  (seg_start),
    .seg_length (seg_length),
    .fit_found  (fit_found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    mem_we         = 1'b0;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = in_address[BIT_AW +: WORD_AW];
    clear_all      = 1'b0;
    scan_ctl       = '0;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          pos_next = '0;
          case (op_t'(s_tuser))
            OP_SET, OP_QUERY: begin
              mem_re     = 1'b1;
              state_next = ST_RMW;
            end
            OP_SEARCH: begin
              mem_re        = 1'b1;
              mem_raddr     = '0;
              scan_ctl.init = 1'b1;
              state_next    = ST_SCAN;
            end
            default: begin
              clear_all  = 1'b1;
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_RMW: begin
        if (op_q == OP_SET) begin
          mem_we                           = 1'b1;
          mem_wdata[addr_q[BIT_AW-1:0]]    = bit_q;
        end
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        scan_ctl.step  = 1'b1;
        scan_ctl.alloc = mem_rdata[pos[BIT_AW-1:0]];
        pos_next       = pos + 1'b1;
        if (pos[BIT_AW-1:0] == BIT_AW'(WORD_BITS - 1)) begin
          mem_re    = 1'b1;
          mem_raddr = WORD_AW'(pos[POS_W-1:BIT_AW] + 1'b1);
        end
        if (pos == POS_W'(MAP_BITS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (accept) begin
      op_q   <= op_t'(s_tuser);
      addr_q <= in_address;
      bit_q  <= s_tdata[ADDR_W];
      wipe_q <= s_tdata[ADDR_W+1];
      need_q <= s_tdata[ADDR_W+2 +: LEN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_bit_read <= 1'b0;
      res_erase    <= 1'b0;
    end else if (state == ST_RMW) begin
      res_bit_read <= (op_q == OP_QUERY) && mem_rdata[addr_q[BIT_AW-1:0]];
      res_erase    <= (op_q == OP_SET) && wipe_q && !bit_q;
    end
  end

  assign out_start      = (op_q == OP_SEARCH) ? ADDR_W'(seg_start) : '0;
  assign out_length     = (op_q == OP_SEARCH) ? seg_length : '0;
  assign out_fit        = (op_q == OP_SEARCH) && fit_found;
  assign out_erase_addr = res_erase ? addr_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, out_erase_addr, res_erase, out_fit, out_length, out_start,
                  res_bit_read};
    end
  end

endmodule

// ===== rtl/bba_checker.sv =====
// Port-level checker of the bitmap best-fit allocator and its bind.
module bba_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bba_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import bba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed or was dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("A second request was taken while one is in progress.");

  a_fit_has_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22] |-> m_tdata[21:11] != '0)
    else $error("Fit reported with zero run length.");

  a_erase_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23] |-> !m_tdata[0] && m_tdata[21:11] == '0 && !m_tdata[22])
    else $error("Erase request mixed with query or search fields.");

  a_no_erase_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[23] |-> m_tdata[33:24] == '0)
    else $error("Erase address shown without an erase request.");

endmodule

bind bitmap_best_fit_allocator bba_checker u_bba_checker (.*);
